>>> design/css_min_pkg.sv
// Shared types, character codes and scanner mode codes for the CSS stream minifier.
`default_nettype none

package css_min_pkg;

   // Character codes recognized by the scanner.
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   // Scanner mode codes.
   localparam logic [3:0] MODE_NORMAL     = 4'd0;
   localparam logic [3:0] MODE_SLASH      = 4'd1;
   localparam logic [3:0] MODE_OPEN       = 4'd2;
   localparam logic [3:0] MODE_DROP       = 4'd3;
   localparam logic [3:0] MODE_DROP_STAR  = 4'd4;
   localparam logic [3:0] MODE_KEEP       = 4'd5;
   localparam logic [3:0] MODE_KEEP_STAR  = 4'd6;
   localparam logic [3:0] MODE_STRING     = 4'd7;
   localparam logic [3:0] MODE_STRING_ESC = 4'd8;
   localparam logic [3:0] MODE_ESC        = 4'd9;

   localparam int unsigned MAX_RESULTS = 3;

   // All results caused by one input transaction, queued as one entry.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [1:0]                  num;
      logic                        has_bytes;
      logic                        last;
      logic                        unclosed;
   } group_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
   endfunction

   // Appends one byte to a result group.
   function automatic group_type put_byte(input group_type g, input logic [7:0] b);
      group_type r;
      r = g;
      if (r.num != 2'd3) begin
         r.bytes[r.num] = b;
         r.num = r.num + 2'd1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/css_min_scan.sv
// Scanner state and combinational byte classification for the CSS stream minifier.
`default_nettype none

module css_min_scan
   import css_min_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] in_byte,
   input  wire logic       end_of_text,
   output group_type       group,
   output logic            push
);

   logic [3:0] mode_ff, mode_in;
   logic       quote_dbl_ff, quote_dbl_in;
   logic       space_ff, space_in;

   always_comb begin
      group_type g;
      logic [3:0] m;
      logic       sp;
      logic       qd;
      logic       do_plain;

      g        = '0;
      m        = mode_ff;
      sp       = space_ff;
      qd       = quote_dbl_ff;
      do_plain = 1'b0;

      unique case (mode_ff) inside
         MODE_SLASH: begin
            if (in_byte == CH_STAR) begin
               m = MODE_OPEN;
            end else begin
               if (sp) begin
                  g  = put_byte(g, CH_SPACE);
                  sp = 1'b0;
               end
               g        = put_byte(g, CH_SLASH);
               m        = MODE_NORMAL;
               do_plain = 1'b1;
            end
         end
         MODE_OPEN: begin
            if (in_byte == CH_BANG) begin
               g = put_byte(g, CH_SLASH);
               g = put_byte(g, CH_STAR);
               g = put_byte(g, CH_BANG);
               m = MODE_KEEP;
            end else begin
               m = (in_byte == CH_STAR) ? MODE_DROP_STAR : MODE_DROP;
            end
         end
         MODE_DROP, MODE_DROP_STAR: begin
            if (mode_ff == MODE_DROP_STAR && in_byte == CH_SLASH) begin
               m = MODE_NORMAL;
            end else begin
               m = (in_byte == CH_STAR) ? MODE_DROP_STAR : MODE_DROP;
            end
         end
         MODE_KEEP, MODE_KEEP_STAR: begin
            g = put_byte(g, in_byte);
            if (mode_ff == MODE_KEEP_STAR && in_byte == CH_SLASH) begin
               m = MODE_NORMAL;
            end else begin
               m = (in_byte == CH_STAR) ? MODE_KEEP_STAR : MODE_KEEP;
            end
         end
         MODE_STRING: begin
            g = put_byte(g, in_byte);
            if (in_byte == CH_BSLASH) begin
               m = MODE_STRING_ESC;
            end else if (in_byte == (qd ? CH_DQUOTE : CH_SQUOTE)) begin
               m = MODE_NORMAL;
            end
         end
         MODE_STRING_ESC: begin
            g = put_byte(g, in_byte);
            m = MODE_STRING;
         end
         MODE_ESC: begin
            g = put_byte(g, in_byte);
            m = MODE_NORMAL;
         end
         default: begin
            m        = MODE_NORMAL;
            do_plain = 1'b1;
         end
      endcase

      // Handling of a byte seen outside strings and comments.
      if (do_plain) begin
         if (in_byte == CH_SLASH) begin
            m = MODE_SLASH;
         end else if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE) begin
            g  = put_byte(g, in_byte);
            qd = (in_byte == CH_DQUOTE);
            m  = MODE_STRING;
         end else if (is_space(in_byte)) begin
            sp = 1'b1;
         end else begin
            if (sp) begin
               g  = put_byte(g, CH_SPACE);
               sp = 1'b0;
            end
            g = put_byte(g, in_byte);
            if (in_byte == CH_BSLASH) begin
               m = MODE_ESC;
            end
         end
      end

      if (end_of_text) begin
         if (m == MODE_SLASH) begin
            if (sp) begin
               g = put_byte(g, CH_SPACE);
            end
            g = put_byte(g, CH_SLASH);
         end
         g.unclosed = (m == MODE_KEEP) || (m == MODE_KEEP_STAR);
         g.last     = 1'b1;
      end

      g.has_bytes = (g.num != 2'd0);
      if (end_of_text && !g.has_bytes) begin
         g.num = 2'd1;   // bare end marker
      end

      group = g;
      push  = accept && (g.num != 2'd0);

      if (end_of_text) begin
         mode_in      = MODE_NORMAL;
         space_in     = 1'b0;
         quote_dbl_in = 1'b0;
      end else begin
         mode_in      = m;
         space_in     = sp;
         quote_dbl_in = qd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         space_ff     <= 1'b0;
         quote_dbl_ff <= 1'b0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         space_ff     <= space_in;
         quote_dbl_ff <= quote_dbl_in;
      end
   end

endmodule

`default_nettype wire

>>> design/css_min_queue.sv
// Result group queue that hands out one result byte or a bare end mark per transaction.
`default_nettype none

module css_min_queue
   import css_min_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire group_type  push_group,
   output logic            full,
   output logic            out_valid,
   input  wire logic       out_stall,
   output logic [7:0]      out_byte,
   output logic            out_byte_valid,
   output logic            out_end,
   output logic            out_unclosed
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   group_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       sub_ff, sub_in;
   group_type        head;
   logic             take, pop, last_sub;

   assign head      = mem_ff[rd_ptr_ff];
   assign full      = (count_ff == CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign last_sub  = (sub_ff == (head.num - 2'd1));
   assign take      = out_valid && !out_stall;
   assign pop       = take && last_sub;

   assign out_byte       = head.has_bytes ? head.bytes[sub_ff] : 8'h00;
   assign out_byte_valid = head.has_bytes;
   assign out_end        = head.last && last_sub;
   assign out_unclosed   = head.unclosed && head.last && last_sub;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (pop) begin
         sub_in = 2'd0;
      end else if (take) begin
         sub_in = sub_ff + 2'd1;
      end else begin
         sub_in = sub_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= 2'd0;
      end else begin
         count_ff <= count_in;
         sub_ff   <= sub_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

>>> design/css_stream_minifier_top.sv
// Top level of the CSS stream minifier: scanner plus result queue.
//
//   Channel | Ports            | Direction | Moves per transaction
//   --------+------------------+-----------+-----------------------------------
//   request | req_valid/stall  | in        | one source byte and end_of_text
//   response| rsp_valid/stall  | out       | one output byte or a bare end mark
//
// A request transaction is classified in the cycle it is accepted; its result, one
// to three bytes or a bare end mark, goes as one group into the result queue at
// that edge. The first response of a group can be taken in the following cycle,
// and the queue then hands out one response transaction per cycle while rsp_stall
// is low. The request side accepts one transaction per cycle while a group slot is
// free, so req_stall rises only when DEPTH groups wait for the response side.
// Synchronous reset returns the scanner to its normal mode and empties the queue.
// After a transaction marked end_of_text the scanner state returns to reset values.
`default_nettype none

module css_stream_minifier_top
   import css_min_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_end_of_text,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_end_of_output,
   output logic            rsp_unclosed_comment
);

   logic      accept;
   logic      push;
   logic      full;
   group_type group;

   // A request is taken whenever the queue has room for its whole group.
   assign req_stall = full;
   assign accept    = req_valid && !full;

   css_min_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .group       (group),
      .push        (push)
   );

   css_min_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .push_group     (group),
      .full           (full),
      .out_valid      (rsp_valid),
      .out_stall      (rsp_stall),
      .out_byte       (rsp_out_byte),
      .out_byte_valid (rsp_byte_valid),
      .out_end        (rsp_end_of_output),
      .out_unclosed   (rsp_unclosed_comment)
   );

`ifndef SYNTHESIS
   // An unclosed-comment flag may only ride on the final response of a text.
   a_unclosed_on_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unclosed_comment |-> rsp_end_of_output)
      else $error("unclosed_comment raised on a non-final response");

   // A bare end marker carries a zero byte and closes the text.
   a_bare_marker : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_end_of_output && (rsp_out_byte == 8'h00))
      else $error("bare marker malformed");

   // A full queue always has a response to offer.
   a_stall_means_data : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty queue");

   // Reset leaves the queue empty.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("queue not empty after reset");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the CSS stream minifier with its own scanner prediction.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import css_min_pkg::*;

   // A run with no accepted transaction on either channel for this many cycles is a hang.
   localparam int STALL_LIMIT = 2000;
   // Number of mismatches that are printed in full; later ones are only counted.
   localparam int REPORT_LIMIT = 10;

   // One response transaction as the block presents it.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_output;
      logic       unclosed_comment;
   } css_output_type;

   // Building blocks of the random CSS texts.
   typedef enum int {
      TOK_WORD,
      TOK_BLANKS,
      TOK_STRING,
      TOK_DROP_COMMENT,
      TOK_KEEP_COMMENT,
      TOK_SLASH,
      TOK_ESCAPE,
      TOK_NOISE
   } token_kind_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_end_of_output;
   logic       rsp_unclosed_comment;

   // Scanner state as the predictor tracks it.
   logic [3:0] scan_state = MODE_NORMAL;
   logic       in_dquote = 1'b0;
   logic       space_owed = 1'b0;

   // Output bytes produced by the byte currently being predicted.
   logic [7:0] step_bytes[$];
   // Minified output that the block still owes, oldest first.
   css_output_type expected_output[$];
   // The text that is sent next, one byte per request transaction.
   logic [7:0] text_buf[$];

   // Idle rates in percent; the receiver rate is read by another process, so it is
   // only ever changed with nonblocking assignments.
   int send_idle_pct = 18;
   int recv_idle_pct = 88;

   int n_fail = 0;
   int n_texts = 0;
   int n_bytes_in = 0;
   int n_outputs = 0;
   int n_open_kept = 0;
   int n_bare_ends = 0;

   css_stream_minifier_top uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_in_byte          (req_in_byte),
      .req_end_of_text      (req_end_of_text),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_byte_valid       (rsp_byte_valid),
      .rsp_end_of_output    (rsp_end_of_output),
      .rsp_unclosed_comment (rsp_unclosed_comment)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction of the minified output.
   // ------------------------------------------------------------------------

   // At most three output bytes can follow from one source byte.
   task automatic emit(input logic [7:0] b);
      if (step_bytes.size() < MAX_RESULTS) begin
         step_bytes.push_back(b);
      end
   endtask

   // A collapsed whitespace run turns into one space only when something visible follows.
   task automatic pay_space();
      if (space_owed) begin
         emit(CH_SPACE);
         space_owed = 1'b0;
      end
   endtask

   // Handling of a byte seen outside strings, comments and escapes.
   task automatic scan_plain(input logic [7:0] b);
      case (b)
         CH_SLASH: begin
            scan_state = MODE_SLASH;
         end
         CH_DQUOTE, CH_SQUOTE: begin
            // The owed space stays owed across the quoted string.
            emit(b);
            in_dquote = (b == CH_DQUOTE);
            scan_state = MODE_STRING;
         end
         CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
            space_owed = 1'b1;
         end
         CH_BSLASH: begin
            pay_space();
            emit(b);
            scan_state = MODE_ESC;
         end
         default: begin
            pay_space();
            emit(b);
         end
      endcase
   endtask

   // Works out the response transactions that one accepted source byte causes and
   // queues them in order.
   task automatic predict_output(input logic [7:0] b, input logic last);
      logic           open_at_end;
      css_output_type item;
      step_bytes.delete();
      open_at_end = 1'b0;
      case (scan_state)
         MODE_SLASH: begin
            if (b == CH_STAR) begin
               scan_state = MODE_OPEN;
            end else begin
               // The held slash was a plain slash after all.
               pay_space();
               emit(CH_SLASH);
               scan_state = MODE_NORMAL;
               scan_plain(b);
            end
         end
         MODE_OPEN: begin
            if (b == CH_BANG) begin
               emit(CH_SLASH);
               emit(CH_STAR);
               emit(CH_BANG);
               scan_state = MODE_KEEP;
            end else begin
               // A star right after the opener can already begin the closing pair.
               scan_state = (b == CH_STAR) ? MODE_DROP_STAR : MODE_DROP;
            end
         end
         MODE_DROP, MODE_DROP_STAR: begin
            if (scan_state == MODE_DROP_STAR && b == CH_SLASH) begin
               scan_state = MODE_NORMAL;
            end else begin
               scan_state = (b == CH_STAR) ? MODE_DROP_STAR : MODE_DROP;
            end
         end
         MODE_KEEP, MODE_KEEP_STAR: begin
            emit(b);
            if (scan_state == MODE_KEEP_STAR && b == CH_SLASH) begin
               scan_state = MODE_NORMAL;
            end else begin
               scan_state = (b == CH_STAR) ? MODE_KEEP_STAR : MODE_KEEP;
            end
         end
         MODE_STRING: begin
            emit(b);
            if (b == CH_BSLASH) begin
               scan_state = MODE_STRING_ESC;
            end else if (b == (in_dquote ? CH_DQUOTE : CH_SQUOTE)) begin
               scan_state = MODE_NORMAL;
            end
         end
         MODE_STRING_ESC: begin
            emit(b);
            scan_state = MODE_STRING;
         end
         MODE_ESC: begin
            emit(b);
            scan_state = MODE_NORMAL;
         end
         default: begin
            scan_state = MODE_NORMAL;
            scan_plain(b);
         end
      endcase

      if (last) begin
         // A slash still held at the end is released; trailing whitespace is not.
         if (scan_state == MODE_SLASH) begin
            pay_space();
            emit(CH_SLASH);
         end
         open_at_end = (scan_state == MODE_KEEP || scan_state == MODE_KEEP_STAR);
         if (open_at_end) begin
            n_open_kept++;
         end
      end

      foreach (step_bytes[k]) begin
         item.out_byte         = step_bytes[k];
         item.byte_valid       = 1'b1;
         item.end_of_output    = last && (k == step_bytes.size() - 1);
         item.unclosed_comment = item.end_of_output && open_at_end;
         expected_output.push_back(item);
      end

      if (last) begin
         // The end of the text must be marked even when nothing is left to emit.
         if (step_bytes.size() == 0) begin
            item.out_byte         = 8'h00;
            item.byte_valid       = 1'b0;
            item.end_of_output    = 1'b1;
            item.unclosed_comment = open_at_end;
            expected_output.push_back(item);
            n_bare_ends++;
         end
         scan_state = MODE_NORMAL;
         in_dquote  = 1'b0;
         space_owed = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------------

   // Sends one source byte as a request transaction. Valid is left high on return so
   // that back-to-back transactions never lower and raise it in the same time step.
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_in_byte     <= b;
      req_end_of_text <= last;
      do @(posedge clock); while (req_stall);
      predict_output(b, last);
      n_bytes_in++;
   endtask

   // Sends the buffered text and marks its final byte as the end of the text.
   task automatic send_text();
      foreach (text_buf[i]) begin
         send_byte(text_buf[i], i == text_buf.size() - 1);
      end
      n_texts++;
   endtask

   task automatic send_string(input string s);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++) begin
         text_buf.push_back(s[i]);
      end
      send_text();
   endtask

   // Holds the request side idle until the block has delivered everything it owes.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_output.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------------
   // Random text generation.
   // ------------------------------------------------------------------------

   // Mostly the bytes that steer the scanner, otherwise anything at all.
   function automatic logic [7:0] tricky_byte();
      case ($urandom_range(0, 9))
         0: return CH_STAR;
         1: return CH_SLASH;
         2: return CH_BSLASH;
         3: return CH_DQUOTE;
         4: return CH_SQUOTE;
         5: return CH_BANG;
         6: return CH_SPACE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_LF;
         default: return CH_CR;
      endcase
   endfunction

   task automatic add_token();
      token_kind_type kind;
      logic [7:0]     quote;
      kind = token_kind_type'($urandom_range(0, 7));
      case (kind)
         TOK_WORD: begin
            repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
         end
         TOK_BLANKS: begin
            repeat ($urandom_range(1, 3)) text_buf.push_back(blank_byte());
         end
         TOK_STRING: begin
            quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            text_buf.push_back(quote);
            repeat ($urandom_range(0, 4)) begin
               if ($urandom_range(0, 4) == 0) begin
                  text_buf.push_back(CH_BSLASH);
               end
               text_buf.push_back(tricky_byte());
            end
            text_buf.push_back(quote);
         end
         TOK_DROP_COMMENT, TOK_KEEP_COMMENT: begin
            text_buf.push_back(CH_SLASH);
            text_buf.push_back(CH_STAR);
            if (kind == TOK_KEEP_COMMENT) begin
               text_buf.push_back(CH_BANG);
            end
            repeat ($urandom_range(0, 4)) text_buf.push_back(tricky_byte());
            text_buf.push_back(CH_STAR);
            text_buf.push_back(CH_SLASH);
         end
         TOK_SLASH: begin
            text_buf.push_back(CH_SLASH);
         end
         TOK_ESCAPE: begin
            text_buf.push_back(CH_BSLASH);
            text_buf.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            text_buf.push_back(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   // Builds a text from well-formed pieces; about one in four is cut short so that
   // texts also end inside strings, comments, escapes and openers.
   task automatic build_random_text();
      int cut;
      text_buf.delete();
      repeat ($urandom_range(1, 8)) add_token();
      if ($urandom_range(0, 99) < 25) begin
         cut = $urandom_range(1, text_buf.size());
         while (text_buf.size() > cut) begin
            void'(text_buf.pop_back());
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Byte values at both ends of the range, every whitespace byte in two runs, and a
   // text that ends on a held slash with a space owed in front of it.
   task automatic test_extremes_and_blanks();
      text_buf = '{8'h00, CH_SPACE, CH_TAB, 8'hFF, CH_CR, CH_LF, CH_SLASH};
      send_text();
   endtask

   // A star-slash that overlaps the opener does not close the comment, so the first
   // text only closes at its second star-slash and ends with a bare end marker.
   // The second text keeps a comment while the space before it stays owed, and the
   // third ends inside an unfinished opener.
   task automatic test_comments();
      send_string("/*/*/");
      send_string(" /*!*/b");
      send_string("/*");
   endtask

   // A double-quoted string with an escaped quote and a single quote inside, the owed
   // space paid before an escape outside the string, then a single-quoted string and
   // a kept comment that is still open when the text ends.
   task automatic test_strings_and_escapes();
      send_string(" \"\\\"'\"\\x");
      send_string("'a'/*!q");
   endtask

   task automatic test_random_texts(input int target);
      int sent;
      sent = 0;
      while (sent < target) begin
         build_random_text();
         sent += text_buf.size();
         send_text();
         // Now and then the sender waits for the block to run completely dry.
         if ($urandom_range(0, 19) == 0) begin
            drain_results();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls and the check of every response transaction.
   // ------------------------------------------------------------------------

   always @(posedge clock) begin : response_check
      css_output_type got;
      css_output_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_byte, rsp_byte_valid, rsp_end_of_output, rsp_unclosed_comment};
            n_outputs++;
            if (expected_output.size() == 0) begin
               n_fail++;
               if (n_fail <= REPORT_LIMIT) begin
                  $display("Unexpected output: byte %h valid %b end %b unclosed %b",
                           got.out_byte, got.byte_valid, got.end_of_output,
                           got.unclosed_comment);
               end
            end else begin
               want = expected_output.pop_front();
               if (got !== want) begin
                  n_fail++;
                  if (n_fail <= REPORT_LIMIT) begin
                     $display({"Output %0d mismatch (expected/actual): byte %h/%h ",
                               "valid %b/%b end %b/%b unclosed %b/%b"},
                              n_outputs, want.out_byte, got.out_byte, want.byte_valid,
                              got.byte_valid, want.end_of_output, got.end_of_output,
                              want.unclosed_comment, got.unclosed_comment);
                  end
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // The watchdog ends a run that stops moving; any correct run keeps accepting
   // transactions far more often than this.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // First phase: a rarely idle sender against a mostly stalled receiver, which
      // keeps the result queue full and the request side stalled.
      test_extremes_and_blanks();
      test_comments();
      test_strings_and_escapes();
      test_random_texts(100);
      drain_results();

      // Second phase: the roles swap, so the queue mostly runs empty.
      send_idle_pct = 88;
      recv_idle_pct <= 18;
      test_random_texts(120);
      drain_results();

      // Third phase: neither side idles, so transactions run back to back.
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      test_random_texts(120);

      drain_results();
      // The wait that follows catches any response that the block sends beyond the expected ones.
      repeat (8) @(posedge clock);

      $display("Ran %0d texts of %0d source bytes in total; %0d responses came back.",
               n_texts, n_bytes_in, n_outputs);
      $display("%0d texts ended inside a kept comment and %0d ended with a bare marker.",
               n_open_kept, n_bare_ends);
      if (n_fail == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", n_fail);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
design/css_min_pkg.sv
design/css_min_scan.sv
design/css_min_queue.sv
design/css_stream_minifier_top.sv
tb/testbench.sv
